// File: rtl/srpm_pkg.sv
package srpm_pkg;

  localparam int SampleBits = 24;
  localparam int MaxPairs   = 65536;
  localparam int CntW       = 17;
  localparam int SumW       = 63;
  localparam int MagW       = SampleBits;
  localparam int SqW        = 2 * MagW;
  localparam int LevelW     = 17;
  // Q16 log2 value: integer part up to 63 plus 16 fraction bits
  localparam int LogW       = 22;
  // attenuation in Q16, signed with headroom
  localparam int AttW       = 26;

  localparam logic [SumW-1:0]   SumMax   = {SumW{1'b1}};
  localparam logic [CntW-1:0]   CntMax   = CntW'(MaxPairs);
  localparam logic [31:0]       DbK      = 32'd50504453;
  localparam logic [LevelW-1:0] DbFloor  = LevelW'(49152);
  localparam logic [AttW-1:0]   RmsBase  = AttW'(2 * (SampleBits - 1) * 65536);
  localparam logic [AttW-1:0]   PeakBase = AttW'((SampleBits - 1) * 65536);

  // log2 operand select
  typedef enum logic [2:0] {
    LOG_CNT, LOG_SUML, LOG_SUMR, LOG_PKL, LOG_PKR
  } log_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOG_START, ST_LOG_WAIT, ST_LEVEL, ST_LEVEL_WAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic     accum;     // fold the captured word in
    logic     clear;     // clear the accumulators
    logic     log_start; // start a log2 run
    log_sel_t log_sel;
    logic     lvl_start; // turn the attenuation into a level
    logic     out_load;  // present the result word
  } cmd_t;

  typedef struct packed {
    logic log_done;
    logic lvl_done;
  } sts_t;

endpackage

// File: rtl/srpm_if.sv
interface srpm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srpm_pkg::SampleBits-1:0] left_sample;
  logic signed [srpm_pkg::SampleBits-1:0] right_sample;
  logic                                 last_in_block;
  modport source (output valid, left_sample, right_sample, last_in_block, input ready);
  modport sink   (input valid, left_sample, right_sample, last_in_block, output ready);
endinterface

interface srpm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [srpm_pkg::LevelW-1:0] rms_left_db;
  logic signed [srpm_pkg::LevelW-1:0] rms_right_db;
  logic signed [srpm_pkg::LevelW-1:0] peak_left_db;
  logic signed [srpm_pkg::LevelW-1:0] peak_right_db;
  modport source (output valid, rms_left_db, rms_right_db, peak_left_db, peak_right_db,
                  input ready);
  modport sink   (input valid, rms_left_db, rms_right_db, peak_left_db, peak_right_db,
                  output ready);
endinterface

// File: rtl/srpm_ctrl.sv
module srpm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  logic            out_busy,
  output srpm_pkg::cmd_t  cmd,
  input  srpm_pkg::sts_t  sts
);

  srpm_pkg::state_t   state_r, state_nxt;
  srpm_pkg::log_sel_t sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srpm_pkg::ST_IDLE;
      sel_r   <= srpm_pkg::LOG_CNT;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Sequence: accumulate, then five log2 runs, then four levels, then emit
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.log_sel = sel_r;
    in_ready  = 1'b0;
    case (state_r)
      srpm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accum = 1'b1;
          if (in_last) begin
            sel_nxt   = srpm_pkg::LOG_CNT;
            state_nxt = srpm_pkg::ST_LOG_START;
          end
        end
      end
      srpm_pkg::ST_LOG_START: begin
        cmd.log_start = 1'b1;
        state_nxt     = srpm_pkg::ST_LOG_WAIT;
      end
      srpm_pkg::ST_LOG_WAIT: begin
        if (sts.log_done) begin
          case (sel_r)
            srpm_pkg::LOG_CNT:  sel_nxt = srpm_pkg::LOG_SUML;
            srpm_pkg::LOG_SUML: sel_nxt = srpm_pkg::LOG_SUMR;
            srpm_pkg::LOG_SUMR: sel_nxt = srpm_pkg::LOG_PKL;
            srpm_pkg::LOG_PKL:  sel_nxt = srpm_pkg::LOG_PKR;
            default:            sel_nxt = srpm_pkg::LOG_CNT;
          endcase
          state_nxt = (sel_r == srpm_pkg::LOG_PKR) ? srpm_pkg::ST_LEVEL
                                                   : srpm_pkg::ST_LOG_START;
        end
      end
      srpm_pkg::ST_LEVEL: begin
        cmd.lvl_start = 1'b1;
        state_nxt     = srpm_pkg::ST_LEVEL_WAIT;
      end
      srpm_pkg::ST_LEVEL_WAIT: begin
        if (sts.lvl_done) state_nxt = srpm_pkg::ST_OUT;
      end
      srpm_pkg::ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = srpm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srpm_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/srpm_dp.sv
module srpm_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic signed [srpm_pkg::SampleBits-1:0]  left_sample,
  input  logic signed [srpm_pkg::SampleBits-1:0]  right_sample,
  input  srpm_pkg::cmd_t                          cmd,
  output srpm_pkg::sts_t                          sts,
  output logic [srpm_pkg::LevelW-1:0]             lvl_rms_l,
  output logic [srpm_pkg::LevelW-1:0]             lvl_rms_r,
  output logic [srpm_pkg::LevelW-1:0]             lvl_pk_l,
  output logic [srpm_pkg::LevelW-1:0]             lvl_pk_r
);

  localparam int MagW = srpm_pkg::MagW;
  localparam int SumW = srpm_pkg::SumW;
  localparam int CntW = srpm_pkg::CntW;
  localparam int LogW = srpm_pkg::LogW;
  localparam int AttW = srpm_pkg::AttW;
  localparam int LvW  = srpm_pkg::LevelW;

  logic [SumW-1:0] sum_l_r, sum_l_nxt, sum_r_r, sum_r_nxt;
  logic [MagW-1:0] pk_l_r, pk_l_nxt, pk_r_r, pk_r_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  function automatic logic [MagW-1:0] mag(input logic [MagW-1:0] s);
    logic [MagW-1:0] n;
    n = ~s + 1'b1;
    return s[MagW-1] ? n : s;
  endfunction

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                               input logic [2*MagW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + (SumW+1)'(b);
    return s[SumW] ? srpm_pkg::SumMax : s[SumW-1:0];
  endfunction

  // Square and compare one word into the accumulators
  logic [MagW-1:0]   ml, mr;
  logic [2*MagW-1:0] sql, sqr;
  assign ml  = mag(left_sample);
  assign mr  = mag(right_sample);
  assign sql = ml * ml;
  assign sqr = mr * mr;

  always_comb begin
    sum_l_nxt = sum_l_r;
    sum_r_nxt = sum_r_r;
    pk_l_nxt  = pk_l_r;
    pk_r_nxt  = pk_r_r;
    cnt_nxt   = cnt_r;
    if (cmd.clear) begin
      sum_l_nxt = '0;
      sum_r_nxt = '0;
      pk_l_nxt  = '0;
      pk_r_nxt  = '0;
      cnt_nxt   = '0;
    end else if (cmd.accum && cnt_r < srpm_pkg::CntMax) begin
      sum_l_nxt = sat_add(sum_l_r, sql);
      sum_r_nxt = sat_add(sum_r_r, sqr);
      if (ml > pk_l_r) pk_l_nxt = ml;
      if (mr > pk_r_r) pk_r_nxt = mr;
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_l_r <= '0;
      sum_r_r <= '0;
      pk_l_r  <= '0;
      pk_r_r  <= '0;
      cnt_r   <= '0;
    end else begin
      sum_l_r <= sum_l_nxt;
      sum_r_r <= sum_r_nxt;
      pk_l_r  <= pk_l_nxt;
      pk_r_r  <= pk_r_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Shared log2 unit
  logic [63:0]     log_x;
  logic [LogW-1:0] log_q;
  logic            log_done;
  always_comb begin
    case (cmd.log_sel)
      srpm_pkg::LOG_CNT:  log_x = 64'(cnt_r);
      srpm_pkg::LOG_SUML: log_x = 64'(sum_l_r);
      srpm_pkg::LOG_SUMR: log_x = 64'(sum_r_r);
      srpm_pkg::LOG_PKL:  log_x = 64'(pk_l_r);
      default:            log_x = 64'(pk_r_r);
    endcase
  end

  srpm_log2 u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.log_start),
    .x     (log_x),
    .done  (log_done),
    .q     (log_q)
  );

  // Hold the log results
  logic [LogW-1:0] lg_cnt_r, lg_sl_r, lg_sr_r, lg_pl_r, lg_pr_r;
  always_ff @(posedge clk) begin
    if (log_done) begin
      case (cmd.log_sel)
        srpm_pkg::LOG_CNT:  lg_cnt_r <= log_q;
        srpm_pkg::LOG_SUML: lg_sl_r  <= log_q;
        srpm_pkg::LOG_SUMR: lg_sr_r  <= log_q;
        srpm_pkg::LOG_PKL:  lg_pl_r  <= log_q;
        default:            lg_pr_r  <= log_q;
      endcase
    end
  end

  // Level stage: one attenuation per cycle through one multiplier
  logic [2:0]       lv_idx_r, lv_idx_nxt;
  logic             lv_busy_r, lv_busy_nxt;
  logic signed [AttW-1:0] att;
  logic [AttW-1:0]  att_c;
  logic [AttW+32-1:0] prod;
  logic [AttW+32-1:0] db;
  logic [LvW-1:0]   lvl;
  logic             zero_in;
  logic [LvW-1:0]   lv0_r, lv1_r, lv2_r, lv3_r;

  always_comb begin
    case (lv_idx_r[1:0])
      2'd0: begin
        att = $signed(srpm_pkg::RmsBase) + $signed(AttW'(lg_cnt_r)) - $signed(AttW'(lg_sl_r));
        zero_in = (sum_l_r == '0) || (cnt_r == '0);
      end
      2'd1: begin
        att = $signed(srpm_pkg::RmsBase) + $signed(AttW'(lg_cnt_r)) - $signed(AttW'(lg_sr_r));
        zero_in = (sum_r_r == '0) || (cnt_r == '0);
      end
      2'd2: begin
        att = ($signed(srpm_pkg::PeakBase) - $signed(AttW'(lg_pl_r))) <<< 1;
        zero_in = (pk_l_r == '0);
      end
      default: begin
        att = ($signed(srpm_pkg::PeakBase) - $signed(AttW'(lg_pr_r))) <<< 1;
        zero_in = (pk_r_r == '0);
      end
    endcase
    att_c = att[AttW-1] ? '0 : AttW'(att);
    prod  = (AttW+32)'(att_c) * (AttW+32)'(srpm_pkg::DbK);
    db    = (prod + (AttW+32)'(64'h8000_0000)) >> 32;
    if (zero_in || db > (AttW+32)'(srpm_pkg::DbFloor)) lvl = -srpm_pkg::DbFloor;
    else lvl = LvW'(0) - LvW'(db);
  end

  always_comb begin
    lv_idx_nxt  = lv_idx_r;
    lv_busy_nxt = lv_busy_r;
    if (cmd.lvl_start) begin
      lv_busy_nxt = 1'b1;
      lv_idx_nxt  = '0;
    end else if (lv_busy_r) begin
      lv_idx_nxt = lv_idx_r + 1'b1;
      if (lv_idx_r == 3'd3) lv_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_idx_r  <= '0;
      lv_busy_r <= 1'b0;
    end else begin
      lv_idx_r  <= lv_idx_nxt;
      lv_busy_r <= lv_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lv_busy_r) begin
      case (lv_idx_r[1:0])
        2'd0:    lv0_r <= lvl;
        2'd1:    lv1_r <= lvl;
        2'd2:    lv2_r <= lvl;
        default: lv3_r <= lvl;
      endcase
    end
  end

  assign sts.log_done = log_done;
  assign sts.lvl_done = lv_busy_r && (lv_idx_r == 3'd3);
  assign lvl_rms_l = lv0_r;
  assign lvl_rms_r = lv1_r;
  assign lvl_pk_l  = lv2_r;
  assign lvl_pk_r  = lv3_r;

endmodule

// File: rtl/srpm_log2.sv
module srpm_log2 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [63:0]                 x,
  output logic                        done,
  output logic [srpm_pkg::LogW-1:0]   q
);

  // Phases: top-bit search (one bit a cycle), then 16 squaring steps
  logic        busy_r, busy_nxt;
  logic        srch_r, srch_nxt;
  logic [5:0]  e_r, e_nxt;
  logic [63:0] x_r, x_nxt;
  logic [31:0] m_r, m_nxt;
  logic [4:0]  i_r, i_nxt;
  logic [15:0] f_r, f_nxt;
  logic        done_r, done_nxt;
  logic [63:0] sq;
  logic [31:0] mn;

  assign sq = 64'(m_r) * 64'(m_r);
  assign mn = 32'(sq >> 30);

  always_comb begin
    busy_nxt = busy_r;
    srch_nxt = srch_r;
    e_nxt    = e_r;
    x_nxt    = x_r;
    m_nxt    = m_r;
    i_nxt    = i_r;
    f_nxt    = f_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      srch_nxt = 1'b1;
      e_nxt    = 6'd63;
      x_nxt    = x;
      f_nxt    = '0;
      i_nxt    = 5'd15;
    end else if (busy_r && srch_r) begin
      if (x_r[e_r] || e_r == '0) begin
        srch_nxt = 1'b0;
        if (e_r >= 6'd30) m_nxt = 32'(x_r >> (e_r - 6'd30));
        else              m_nxt = 32'(x_r << (6'd30 - e_r));
      end else begin
        e_nxt = e_r - 1'b1;
      end
    end else if (busy_r) begin
      if (mn[31]) begin
        f_nxt[i_r[3:0]] = 1'b1;
        m_nxt = mn >> 1;
      end else begin
        m_nxt = mn;
      end
      i_nxt = i_r - 1'b1;
      if (i_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      srch_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      srch_r <= srch_nxt;
      done_r <= done_nxt;
    end
    e_r <= e_nxt;
    x_r <= x_nxt;
    m_r <= m_nxt;
    i_r <= i_nxt;
    f_r <= f_nxt;
  end

  assign done = done_r;
  assign q    = {e_r, f_r};

endmodule

// File: rtl/stereo_rms_peak_level_meter_unit.sv
// Channel | Dir | Contents
// in      | in  | left_sample, right_sample (24b signed), last_in_block
// out     | out | rms_left_db, rms_right_db, peak_left_db, peak_right_db (17b)
//
// A word without the block flag is only accumulated. The final word of a
// block runs the shared log2 unit on each operand (top-bit search one bit a
// cycle, then 16 squarings), then the level pass over the four levels.
// rst_n clears the accumulators and the controller. A result waiting on a
// stalled output holds the controller; new words are taken once it is loaded.
module stereo_rms_peak_level_meter_unit (
  input logic clk,
  input logic rst_n,
  srpm_in_if.sink    in_ch,
  srpm_out_if.source out_ch
);

  srpm_pkg::cmd_t cmd;
  srpm_pkg::sts_t sts;
  logic [srpm_pkg::LevelW-1:0] l0, l1, l2, l3;
  logic out_valid_r, out_valid_nxt;
  logic [srpm_pkg::LevelW-1:0] o0_r, o1_r, o2_r, o3_r;

  srpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_in_block),
    .in_ready (in_ch.ready),
    .out_busy (out_valid_r && !out_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  srpm_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .cmd          (cmd),
    .sts          (sts),
    .lvl_rms_l    (l0),
    .lvl_rms_r    (l1),
    .lvl_pk_l     (l2),
    .lvl_pk_r     (l3)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (cmd.out_load) begin
      o0_r <= l0;
      o1_r <= l1;
      o2_r <= l2;
      o3_r <= l3;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rms_left_db   = o0_r;
  assign out_ch.rms_right_db  = o1_r;
  assign out_ch.peak_left_db  = o2_r;
  assign out_ch.peak_right_db = o3_r;

endmodule

// File: rtl/srpm_checker.sv
module srpm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic [srpm_pkg::LevelW-1:0] rms_l,
  input logic [srpm_pkg::LevelW-1:0] pk_l
);

  // A flagged word ends intake until the result is built
  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("ready after block end");

  // Levels never positive
  a_rms_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rms_l[srpm_pkg::LevelW-1] || rms_l == '0))
    else $error("rms level above full scale");

  a_pk_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pk_l[srpm_pkg::LevelW-1] || pk_l == '0))
    else $error("peak level above full scale");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rms_l))
    else $error("result dropped");

endmodule

bind stereo_rms_peak_level_meter_unit srpm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_in_block),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .rms_l     (out_ch.rms_left_db),
  .pk_l      (out_ch.peak_left_db)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int IdleLimit  = 20000;
  localparam int PressHold  = 3000;
  localparam int FloorLevel = 49152;

  typedef struct {
    logic signed [srpm_pkg::SampleBits-1:0] left;
    logic signed [srpm_pkg::SampleBits-1:0] right;
    logic                                   last;
  } pair_t;

  typedef struct {
    logic signed [srpm_pkg::LevelW-1:0] rms_l;
    logic signed [srpm_pkg::LevelW-1:0] rms_r;
    logic signed [srpm_pkg::LevelW-1:0] peak_l;
    logic signed [srpm_pkg::LevelW-1:0] peak_r;
  } levels_t;

  // Running meter state plus the queue of level words still due
  class level_scoreboard;
    longint unsigned sum_l, sum_r, pk_l, pk_r, n_pairs;
    levels_t due[$];
    int errors;

    function longint unsigned mag(logic signed [srpm_pkg::SampleBits-1:0] s);
      longint v;
      v = s;
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function longint unsigned add_sat(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > 64'h7FFF_FFFF_FFFF_FFFF || s < a) ? 64'h7FFF_FFFF_FFFF_FFFF : s;
    endfunction

    // log2 in Q16: top bit index, then 16 fraction bits by squaring
    function longint log2_q16(longint unsigned x);
      int e;
      longint unsigned m, frac;
      e = 63;
      frac = 0;
      while (e > 0 && !x[e]) e--;
      m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
      for (int i = 15; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= 64'h8000_0000) begin
          frac |= 64'd1 << i;
          m >>= 1;
        end
      end
      return longint'(e) * 65536 + longint'(frac);
    endfunction

    // attenuation in Q16 log2 units to a negative level in 1/256 dB
    function logic signed [srpm_pkg::LevelW-1:0] to_level(longint d);
      longint unsigned db;
      if (d < 0) d = 0;
      db = (longint'(d) * 64'd50504453 + 64'h8000_0000) >> 32;
      if (db > FloorLevel) db = FloorLevel;
      return srpm_pkg::LevelW'(-longint'(db));
    endfunction

    function logic signed [srpm_pkg::LevelW-1:0] rms_level(longint unsigned s,
                                                            longint unsigned n);
      if (s == 0 || n == 0) return srpm_pkg::LevelW'(-FloorLevel);
      return to_level(longint'(2 * (srpm_pkg::SampleBits - 1)) * 65536
                      + log2_q16(n) - log2_q16(s));
    endfunction

    function logic signed [srpm_pkg::LevelW-1:0] peak_level(longint unsigned p);
      if (p == 0) return srpm_pkg::LevelW'(-FloorLevel);
      return to_level(2 * (longint'(srpm_pkg::SampleBits - 1) * 65536 - log2_q16(p)));
    endfunction

    function void note_pair(pair_t p);
      longint unsigned ml, mr;
      levels_t lv;
      if (n_pairs < srpm_pkg::MaxPairs) begin
        ml = mag(p.left);
        mr = mag(p.right);
        sum_l = add_sat(sum_l, ml * ml);
        sum_r = add_sat(sum_r, mr * mr);
        if (ml > pk_l) pk_l = ml;
        if (mr > pk_r) pk_r = mr;
        n_pairs++;
      end
      if (p.last) begin
        lv.rms_l  = rms_level(sum_l, n_pairs);
        lv.rms_r  = rms_level(sum_r, n_pairs);
        lv.peak_l = peak_level(pk_l);
        lv.peak_r = peak_level(pk_r);
        due.push_back(lv);
        sum_l = 0; sum_r = 0; pk_l = 0; pk_r = 0; n_pairs = 0;
      end
    endfunction

    function void cmp(string name, logic signed [srpm_pkg::LevelW-1:0] exp_v,
                      logic signed [srpm_pkg::LevelW-1:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s expected %0d got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_levels(levels_t got);
      levels_t e;
      if (due.size() == 0) begin
        $error("level word with none due");
        errors++;
        return;
      end
      e = due.pop_front();
      cmp("rms_left_db", e.rms_l, got.rms_l);
      cmp("rms_right_db", e.rms_r, got.rms_r);
      cmp("peak_left_db", e.peak_l, got.peak_l);
      cmp("peak_right_db", e.peak_r, got.peak_r);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  srpm_in_if  in_ch();
  srpm_out_if out_ch();

  stereo_rms_peak_level_meter_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  level_scoreboard sb = new();
  int tx_idle = 0;
  int rx_idle = 0;
  bit hold_req = 0;
  int quiet = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.left_sample = 0;
    in_ch.right_sample = 0;
    in_ch.last_in_block = 0;
    out_ch.ready = 0;
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      out_ch.ready <= 0;
      for (int i = 0; i < PressHold; i++) @(negedge clk);
      hold_req = 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Check level words and watch for a hang
  always @(posedge clk) begin
    levels_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.rms_l  = out_ch.rms_left_db;
      got.rms_r  = out_ch.rms_right_db;
      got.peak_l = out_ch.peak_left_db;
      got.peak_r = out_ch.peak_right_db;
      sb.check_levels(got);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one word and hold it until taken
  task automatic send_pair(pair_t p);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.left_sample <= p.left;
    in_ch.right_sample <= p.right;
    in_ch.last_in_block <= p.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_pair(p);
  endtask

  task automatic send_one(int l, int r, bit last);
    pair_t p;
    p.left = srpm_pkg::SampleBits'(l);
    p.right = srpm_pkg::SampleBits'(r);
    p.last = last;
    send_pair(p);
  endtask

  function automatic logic signed [srpm_pkg::SampleBits-1:0] rand_sample();
    case ($urandom_range(5))
      0: return srpm_pkg::SampleBits'($urandom_range(16));
      1: return -srpm_pkg::SampleBits'($urandom_range(16));
      2: return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
      3: return srpm_pkg::SampleBits'($urandom_range(4095) - 2048);
      default: return srpm_pkg::SampleBits'($urandom);
    endcase
  endfunction

  // Random blocks, mostly short, now and then longer
  task automatic send_blocks(int count);
    int sent, len;
    pair_t p;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 17) : $urandom_range(16, 1);
      for (int i = 0; i < len; i++) begin
        p.left = rand_sample();
        p.right = ($urandom_range(7) == 0) ? srpm_pkg::SampleBits'(0) : rand_sample();
        p.last = (i == len - 1);
        send_pair(p);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: silence, full scale both signs, tiny, bit patterns, lopsided
    send_one(0, 0, 1);
    send_one(-8388608, -8388608, 1);
    send_one(8388607, 8388607, 1);
    send_one(1, -1, 1);
    send_one(0, 8388607, 1);
    send_one(-8388608, 0, 1);
    send_one(24'h555555, 24'hAAAAAA, 0);
    send_one(24'hAAAAAA, 24'h555555, 1);
    send_one(1, 0, 0);
    send_one(0, 0, 0);
    send_one(-1, 0, 1);
    send_one(100, -100, 0);
    send_one(-8388608, 8388607, 0);
    send_one(3, -7, 1);
    for (int i = 0; i < 8; i++) send_one(-1, 1, i == 7);

    tx_idle = 23; rx_idle = 72;
    send_blocks(540);
    tx_idle = 72; rx_idle = 23;
    send_blocks(540);
    tx_idle = 0; rx_idle = 0;
    hold_req = 1;
    send_blocks(550);

    @(negedge clk);
    in_ch.valid <= 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/srpm_pkg.sv
rtl/srpm_if.sv
rtl/srpm_ctrl.sv
rtl/srpm_dp.sv
rtl/srpm_log2.sv
rtl/stereo_rms_peak_level_meter_unit.sv
rtl/srpm_checker.sv
tb/tb.sv
